FILE: hw/rtl/lpbdm_pkg.sv
// Shared types and constants for the LRU page buffer with dirty marks.
package lpbdm_pkg;

    localparam int PAGE_W        = 32;
    localparam int CMD_W         = 3;
    localparam int STATUS_W      = 2;
    localparam int LIMIT_W       = 5;
    localparam int CFG_IDX_W     = 1;
    localparam int DEF_SLOTS     = 16;
    localparam int DEF_MIN_LIMIT = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_OPEN     = 3'd0,
        CMD_CLOSE    = 3'd1,
        CMD_GET      = 3'd2,
        CMD_GET_NEW  = 3'd3,
        CMD_MARK     = 3'd4
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 2'd0,
        ST_NOT_OPEN     = 2'd1,
        ST_NOT_RESIDENT = 2'd2
    } t_status;

    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_LIMIT       = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_PAGE_COUNT = 1'd1;

endpackage

FILE: hw/rtl/lru_page_buffer_with_dirty_marks.sv
// Fully associative page buffer with LRU replacement, dirty marks and writeback report.
// An accepted item enters the input register; when it fires, the result register is
// loaded and drives the outputs. Throughput: one item per cycle without i_out_stall;
// each item is looked up, aged and updated by one parallel compare/age pass between
// the input register and the result register.
// Reset (synchronous, active low) clears all slots, the open flag, the page count
// and both configuration registers; no clearing pass is needed.
module lru_page_buffer_with_dirty_marks
    import lpbdm_pkg::*;
#(
    parameter int SLOTS     = DEF_SLOTS,
    parameter int MIN_LIMIT = DEF_MIN_LIMIT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [PAGE_W-1:0]    i_cfg_data,
    // command channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [CMD_W-1:0]     i_cmd,
    input  logic [PAGE_W-1:0]    i_page_id,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [STATUS_W-1:0]  o_status,
    output logic                 o_hit,
    output logic [PAGE_W-1:0]    o_result_page,
    output logic                 o_evicted,
    output logic [PAGE_W-1:0]    o_evicted_page,
    output logic                 o_writeback
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int OW = $clog2(SLOTS + 1);
    localparam int LW = (OW > LIMIT_W) ? OW : LIMIT_W;

    // configuration registers
    logic [LIMIT_W-1:0] r_buffer_limit;
    logic [PAGE_W-1:0]  r_init_count;

    // input stage
    logic               r_in_valid;
    logic [CMD_W-1:0]   r_cmd;
    logic [PAGE_W-1:0]  r_page_id;

    // buffer state
    logic [PAGE_W-1:0]  r_page [SLOTS];
    logic [SLOTS-1:0]   r_valid, n_valid;
    logic [SLOTS-1:0]   r_dirty, n_dirty;
    logic [AW-1:0]      r_age [SLOTS];
    logic [AW-1:0]      n_age [SLOTS];
    logic [OW-1:0]      r_occ, n_occ;
    logic [PAGE_W-1:0]  r_page_count, n_page_count;
    logic               r_is_open, n_is_open;

    // result register
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status, n_status;
    logic                r_hit, n_hit;
    logic [PAGE_W-1:0]   r_result_page, n_result_page;
    logic                r_evicted, n_evicted;
    logic [PAGE_W-1:0]   r_evicted_page, n_evicted_page;
    logic                r_writeback, n_writeback;

    logic               fire;
    logic               accept;
    logic [PAGE_W-1:0]  next_page;
    logic [PAGE_W-1:0]  pid_sel;
    logic [LW-1:0]      eff_limit;
    logic               need_evict;
    logic [SLOTS-1:0]   hit_vec;
    logic [AW-1:0]      hit_age;
    logic [OW-1:0]      occ_m1;
    logic [SLOTS-1:0]   victim_vec;
    logic [SLOTS-1:0]   evict_vec;
    logic [PAGE_W-1:0]  victim_page;
    logic               victim_dirty;
    logic [SLOTS-1:0]   kept;
    logic [SLOTS-1:0]   free_onehot;
    logic               free_found;
    logic               ins_en;

    assign fire       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !fire;
    assign accept     = i_in_valid && !o_in_stall;

    assign next_page = r_page_count + PAGE_W'(1);
    assign pid_sel   = (r_cmd == CMD_GET_NEW) ? next_page : r_page_id;

    always_comb begin
        eff_limit = LW'(r_buffer_limit);
        if (eff_limit == '0 || eff_limit > LW'(SLOTS)) begin
            eff_limit = LW'(SLOTS);
        end
        if (eff_limit < LW'(MIN_LIMIT)) begin
            eff_limit = LW'(MIN_LIMIT);
        end
        if (eff_limit > LW'(SLOTS)) begin
            eff_limit = LW'(SLOTS);
        end
    end

    assign need_evict = LW'(r_occ) >= eff_limit;
    assign occ_m1     = r_occ - OW'(1);

    // Valid ages are always a permutation of 0..occ-1, so the LRU slot
    // is the one whose age equals occ-1.
    always_comb begin
        hit_age      = '0;
        victim_page  = '0;
        victim_dirty = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            hit_vec[i]    = r_valid[i] && (r_page[i] == pid_sel);
            victim_vec[i] = r_valid[i] && (r_age[i] == occ_m1[AW-1:0]);
            if (hit_vec[i]) begin
                hit_age = hit_age | r_age[i];
            end
            if (victim_vec[i]) begin
                victim_page  = victim_page | r_page[i];
                victim_dirty = victim_dirty | r_dirty[i];
            end
        end
    end

    assign evict_vec = need_evict ? victim_vec : '0;
    assign kept      = r_valid & ~evict_vec;

    // first free slot after the eviction
    always_comb begin
        free_onehot = '0;
        free_found  = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            if (!kept[i] && !free_found) begin
                free_onehot[i] = 1'b1;
                free_found     = 1'b1;
            end
        end
    end

    always_comb begin
        n_valid        = r_valid;
        n_dirty        = r_dirty;
        n_age          = r_age;
        n_occ          = r_occ;
        n_page_count   = r_page_count;
        n_is_open      = r_is_open;
        ins_en         = 1'b0;
        n_status       = ST_OK;
        n_hit          = 1'b0;
        n_result_page  = '0;
        n_evicted      = 1'b0;
        n_evicted_page = '0;
        n_writeback    = 1'b0;

        case (r_cmd)
            CMD_OPEN: begin
                if (!r_is_open) begin
                    n_page_count = r_init_count;
                    n_is_open    = 1'b1;
                end
            end
            CMD_CLOSE: begin
                if (!r_is_open) begin
                    n_status = ST_NOT_OPEN;
                end else begin
                    n_valid   = '0;
                    n_dirty   = '0;
                    n_occ     = '0;
                    n_is_open = 1'b0;
                end
            end
            CMD_GET, CMD_GET_NEW: begin
                if (!r_is_open) begin
                    n_status = ST_NOT_OPEN;
                end else begin
                    if (r_cmd == CMD_GET_NEW) begin
                        n_page_count = next_page;
                    end
                    n_result_page = pid_sel;
                    if (|hit_vec) begin
                        n_hit = 1'b1;
                        for (int i = 0; i < SLOTS; i++) begin
                            if (hit_vec[i]) begin
                                n_age[i] = '0;
                            end else if (r_valid[i] && r_age[i] < hit_age) begin
                                n_age[i] = r_age[i] + AW'(1);
                            end
                        end
                    end else begin
                        if (|evict_vec) begin
                            n_evicted      = 1'b1;
                            n_evicted_page = victim_page;
                            n_writeback    = victim_dirty;
                        end
                        ins_en  = free_found;
                        n_valid = kept | free_onehot;
                        n_dirty = r_dirty & ~evict_vec & ~free_onehot;
                        for (int i = 0; i < SLOTS; i++) begin
                            if (free_onehot[i]) begin
                                n_age[i] = '0;
                            end else if (kept[i] && free_found) begin
                                n_age[i] = r_age[i] + AW'(1);
                            end
                        end
                        n_occ = r_occ - OW'(|evict_vec) + OW'(free_found);
                    end
                end
            end
            CMD_MARK: begin
                if (!r_is_open) begin
                    n_status = ST_NOT_OPEN;
                end else begin
                    n_result_page = r_page_id;
                    if (|hit_vec) begin
                        n_hit   = 1'b1;
                        n_dirty = r_dirty | hit_vec;
                    end else begin
                        n_status = ST_NOT_RESIDENT;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_limit <= '0;
            r_init_count   <= '0;
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_valid        <= '0;
            r_dirty        <= '0;
            r_occ          <= '0;
            r_page_count   <= '0;
            r_is_open      <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                r_age[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BUFFER_LIMIT:       r_buffer_limit <= i_cfg_data[LIMIT_W-1:0];
                    CFG_INITIAL_PAGE_COUNT: r_init_count   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid  <= 1'b1;
                r_valid      <= n_valid;
                r_dirty      <= n_dirty;
                r_age        <= n_age;
                r_occ        <= n_occ;
                r_page_count <= n_page_count;
                r_is_open    <= n_is_open;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd     <= i_cmd;
            r_page_id <= i_page_id;
        end
        if (fire) begin
            r_status       <= n_status;
            r_hit          <= n_hit;
            r_result_page  <= n_result_page;
            r_evicted      <= n_evicted;
            r_evicted_page <= n_evicted_page;
            r_writeback    <= n_writeback;
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (fire && ins_en && free_onehot[i]) begin
                r_page[i] <= pid_sel;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_hit          = r_hit;
    assign o_result_page  = r_result_page;
    assign o_evicted      = r_evicted;
    assign o_evicted_page = r_evicted_page;
    assign o_writeback    = r_writeback;

    a_occ_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_occ))
        else $error("occupancy does not match valid slot count");

    a_closed_is_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_is_open |-> (r_occ == '0 && r_valid == '0))
        else $error("slots resident while buffer is closed");

    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_is_open && r_cmd == CMD_CLOSE) |=> (r_valid == '0 && r_dirty == '0))
        else $error("close left slots behind");

    a_no_stall_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid && r_in_valid) |-> !o_in_stall)
        else $error("input stalled with an empty result register");

endmodule
